@@ hdl/gbts_pkg.sv @@
package gbts_pkg;

    localparam int CAPACITY = 4096;
    localparam int AW = $clog2(CAPACITY);
    localparam int PW = AW + 1;

    localparam logic [2:0] FN_INSERT    = 3'd0;
    localparam logic [2:0] FN_REMOVE    = 3'd1;
    localparam logic [2:0] FN_READ      = 3'd2;
    localparam logic [2:0] FN_LINESTART = 3'd3;
    localparam logic [2:0] FN_POS2LC    = 3'd4;
    localparam logic [2:0] FN_LC2POS    = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_PAST = 2'd2;

    localparam logic [7:0] NEWLINE  = 8'd10;
    localparam logic [7:0] NUL_BYTE = 8'd0;

    typedef struct packed {
        logic [2:0]  func;
        logic [12:0] position;
        logic [7:0]  char_in;
        logic [12:0] line_number;
        logic [12:0] column;
    } t_req;

    typedef struct packed {
        logic [7:0]  char_out;
        logic [12:0] position_out;
        logic [12:0] line_out;
        logic [12:0] col_out;
        logic [12:0] text_length;
        logic [12:0] line_total;
        logic [1:0]  status;
    } t_rsp;

endpackage

@@ hdl/gbts_ram.sv @@
module gbts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

@@ hdl/gbts_ctrl.sv @@
module gbts_ctrl import gbts_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_ready,
    input  t_req          i_req,
    output logic          o_rsp_valid,
    input  logic          i_rsp_ready,
    output t_rsp          o_rsp,
    output logic          o_we,
    output logic [AW-1:0] o_waddr,
    output logic [7:0]    o_wdata,
    output logic [AW-1:0] o_raddr,
    input  logic [7:0]    i_rdata
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SHIFT = 3'd1;
    localparam logic [2:0] S_EDIT = 3'd2;
    localparam logic [2:0] S_WALK = 3'd3;
    localparam logic [2:0] S_READ = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0]    r_state, n_state;
    logic [PW-1:0] r_gb, n_gb, r_gf, n_gf;
    logic [12:0]   r_lt, n_lt;
    t_req          r_req, n_req;
    logic [PW-1:0] r_tgt, n_tgt;
    logic [PW-1:0] r_p, n_p;
    logic [12:0]   r_lines, n_lines, r_cols, n_cols;
    logic          r_phase2, n_phase2;
    logic          r_rd, n_rd;
    logic          r_pend, n_pend;
    logic [AW-1:0] r_pa, n_pa;
    t_rsp          r_rsp, n_rsp;
    logic          r_ov, n_ov;

    logic [PW-1:0] len, gapw, pos_ext;
    logic [PW-1:0] p_clamp;
    logic [PW-1:0] rd_pos;
    logic [PW:0]   phys_w;
    logic          walk_more;

    assign len = PW'(CAPACITY) - (r_gf - r_gb);
    assign gapw = r_gf - r_gb;
    assign pos_ext = PW'(r_req.position);
    assign p_clamp = (pos_ext < len) ? pos_ext : len;
    assign rd_pos = r_p;
    assign phys_w = (rd_pos < r_gb) ? {1'b0, rd_pos} : {1'b0, rd_pos} + {1'b0, gapw};

    assign o_req_ready = (r_state == S_IDLE) && !r_ov;
    assign o_rsp_valid = r_ov;
    assign o_rsp = r_rsp;

    always_comb begin
        n_state = r_state; n_gb = r_gb; n_gf = r_gf; n_lt = r_lt; n_req = r_req;
        n_tgt = r_tgt; n_p = r_p; n_lines = r_lines; n_cols = r_cols;
        n_phase2 = r_phase2; n_rd = 1'b0; n_pend = r_pend; n_pa = r_pa;
        n_rsp = r_rsp; n_ov = r_ov;
        o_we = 1'b0; o_waddr = '0; o_wdata = i_rdata; o_raddr = '0;
        walk_more = 1'b0;
        if (r_ov && i_rsp_ready) begin
            n_ov = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_req_valid && !r_ov) begin
                    n_req = i_req;
                    n_rsp = '0;
                    n_p = '0; n_lines = '0; n_cols = '0; n_phase2 = 1'b0;
                    n_pend = 1'b0;
                    n_state = S_DONE;
                    case (i_req.func)
                        FN_INSERT: begin
                            if (len >= PW'(CAPACITY)) begin
                                n_rsp.status = ST_FULL;
                            end else begin
                                n_tgt = (PW'(i_req.position) < len) ? PW'(i_req.position) : len;
                                n_state = S_SHIFT;
                            end
                        end
                        FN_REMOVE: begin
                            if (PW'(i_req.position) >= len) begin
                                n_rsp.status = ST_PAST;
                            end else begin
                                n_tgt = PW'(i_req.position);
                                n_state = S_SHIFT;
                            end
                        end
                        FN_READ: begin
                            n_p = PW'(i_req.position);
                            if (PW'(i_req.position) < len) n_state = S_READ;
                        end
                        FN_LINESTART: begin
                            if (i_req.line_number >= r_lt) n_rsp.position_out = len[12:0];
                            else n_state = S_WALK;
                        end
                        FN_POS2LC, FN_LC2POS: n_state = S_WALK;
                        default: ;
                    endcase
                end
            end
            S_SHIFT: begin
                if (r_pend) begin
                    o_we = 1'b1; o_waddr = r_pa; o_wdata = i_rdata;
                end
                if (r_tgt < r_gb) begin
                    o_raddr = AW'(r_gb - 1'b1);
                    n_pa = AW'(r_gf - 1'b1);
                    n_gb = r_gb - 1'b1; n_gf = r_gf - 1'b1; n_pend = 1'b1;
                end else if (r_tgt > r_gb && r_gf < PW'(CAPACITY)) begin
                    o_raddr = AW'(r_gf);
                    n_pa = AW'(r_gb);
                    n_gb = r_gb + 1'b1; n_gf = r_gf + 1'b1; n_pend = 1'b1;
                end else if (r_pend) begin
                    // last moved byte lands before the byte at the gap end is read
                    n_pend = 1'b0;
                end else begin
                    o_raddr = AW'(r_gf);
                    n_state = S_EDIT;
                end
            end
            S_EDIT: begin
                if (r_req.func == FN_INSERT) begin
                    o_we = 1'b1; o_waddr = AW'(r_gb); o_wdata = r_req.char_in;
                    n_gb = r_gb + 1'b1;
                    if (r_req.char_in == NEWLINE) n_lt = r_lt + 1'b1;
                end else begin
                    n_gf = r_gf + 1'b1;
                    if (i_rdata == NEWLINE && r_lt > 13'd1) n_lt = r_lt - 1'b1;
                end
                n_state = S_DONE;
            end
            S_READ: begin
                if (!r_rd) begin
                    o_raddr = AW'(phys_w);
                    n_rd = 1'b1;
                end else begin
                    n_rsp.char_out = i_rdata;
                    n_state = S_DONE;
                end
            end
            S_WALK: begin
                case (r_req.func)
                    FN_LINESTART: walk_more = (r_lines < r_req.line_number) && (r_p < len);
                    FN_POS2LC: walk_more = r_p < p_clamp;
                    default: walk_more = (r_p < len) && (r_phase2
                        ? (r_cols < r_req.column) : (r_lines < r_req.line_number));
                endcase
                if (!r_rd) begin
                    if (walk_more) begin
                        o_raddr = AW'(phys_w);
                        n_rd = 1'b1;
                    end else if (r_req.func == FN_LC2POS && !r_phase2) begin
                        n_phase2 = 1'b1;
                    end else begin
                        n_rsp.position_out = r_p[12:0];
                        if (r_req.func == FN_POS2LC) begin
                            n_rsp.line_out = r_lines;
                            n_rsp.col_out = r_cols;
                        end
                        n_state = S_DONE;
                    end
                end else if (r_phase2 && i_rdata == NEWLINE) begin
                    n_rsp.position_out = r_p[12:0];
                    n_state = S_DONE;
                end else begin
                    n_p = r_p + 1'b1;
                    if (i_rdata == NEWLINE) begin
                        n_lines = r_lines + 1'b1; n_cols = '0;
                    end else begin
                        n_cols = r_cols + 1'b1;
                    end
                end
            end
            S_DONE: begin
                n_rsp.text_length = len[12:0];
                n_rsp.line_total = r_lt;
                n_ov = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_gb <= '0; r_gf <= PW'(CAPACITY); r_lt <= 13'd1;
            r_ov <= 1'b0; r_rd <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_state <= n_state; r_gb <= n_gb; r_gf <= n_gf; r_lt <= n_lt;
            r_ov <= n_ov; r_rd <= n_rd; r_pend <= n_pend;
        end
        r_req <= n_req; r_tgt <= n_tgt; r_p <= n_p; r_lines <= n_lines;
        r_cols <= n_cols; r_phase2 <= n_phase2; r_pa <= n_pa; r_rsp <= n_rsp;
    end

    a_gap_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gb <= r_gf) else $error("gap inverted");
    a_gap_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_gf <= PW'(CAPACITY)) else $error("gap end past capacity");
    a_lines_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lt != 13'd0) else $error("line total zero");
    a_ready_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_req_ready |-> !o_rsp_valid) else $error("accept while result pending");
endmodule

@@ hdl/gap_buffer_text_store.sv @@
// Channel | Dir | Handshake                  | Payload
// s_axis  | in  | s_axis_tvalid/tready       | tdata: func, position, char_in, line_number, column
// m_axis  | out | m_axis_tvalid/tready       | tdata: char_out, position_out, line_out,
//         |     |                            |        col_out, text_length, line_total, status
// One item at a time: the next request is accepted once the last result has left m_axis.
// Insert/remove first move the gap to the target position, one byte moved per
// cycle through the single text RAM port pair. In-range reads fetch one byte.
// Line walks read the text byte by byte from position 0. Rejected, past-end,
// line-past-last and unused requests skip the RAM. Reset (i_rst_n low,
// synchronous) empties the text; RAM contents are not cleared. Input waits on m_axis.
module gap_buffer_text_store import gbts_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [55:0] s_axis_tdata,  // func, position, char_in, line_number, column
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata   // char_out, position_out, line_out, col_out,
                                       // text_length, line_total, status
);
    t_req          req;
    t_rsp          rsp;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [7:0]    wdata, rdata;

    assign req.func        = s_axis_tdata[2:0];
    assign req.position    = s_axis_tdata[15:3];
    assign req.char_in     = s_axis_tdata[23:16];
    assign req.line_number = s_axis_tdata[36:24];
    assign req.column      = s_axis_tdata[49:37];

    assign m_axis_tdata = {5'd0, rsp.status, rsp.line_total, rsp.text_length,
                           rsp.col_out, rsp.line_out, rsp.position_out, rsp.char_out};

    gbts_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(s_axis_tvalid), .o_req_ready(s_axis_tready), .i_req(req),
        .o_rsp_valid(m_axis_tvalid), .i_rsp_ready(m_axis_tready), .o_rsp(rsp),
        .o_we(we), .o_waddr(waddr), .o_wdata(wdata), .o_raddr(raddr), .i_rdata(rdata)
    );

    gbts_ram #(.WIDTH(8), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );
endmodule
